### rtl/rds_pkg.sv
package rds_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned POS_W   = 12;
	localparam int unsigned OCC_W   = 13;
	localparam int unsigned REQ_W   = 3;
	localparam int unsigned STAT_W  = 2;

	// byte-padded widths of the stream payloads
	localparam int unsigned S_TDATA_W = 48;
	localparam int unsigned M_TDATA_W = 48;

	typedef enum logic [REQ_W-1:0] {
		REQ_APPEND    = 3'd0,
		REQ_INSERT    = 3'd1,
		REQ_POP_FIRST = 3'd2,
		REQ_POP_LAST  = 3'd3,
		REQ_READ      = 3'd4,
		REQ_REVERSE   = 3'd5
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2,
		STAT_RANGE = 2'd3
	} stat_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_RESP = 1'b1
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
	} rds_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
	} rds_stat_t;

endpackage

### rtl/rds_ctrl.sv
module rds_ctrl
	import rds_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      out_ready,
	input  rds_stat_t dp_stat,
	output logic      in_ready,
	output logic      out_valid,
	output rds_cmd_t  cmd,
	output logic      busy_full
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd.load  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_RESP;
				end
			end
			S_RESP: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// store state as seen after the last transaction
	assign busy_full = dp_stat.full & ~dp_stat.empty;

endmodule

### rtl/rds_datapath.sv
module rds_datapath
	import rds_pkg::*;
#(
	parameter int unsigned DEPTH = 16
)
(
	input  logic                clk,
	input  logic                arst_n,
	input  rds_cmd_t            cmd,
	input  req_t                req,
	input  logic [VALUE_W-1:0]  value,
	input  logic [POS_W-1:0]    position,
	output rds_stat_t           dp_stat,
	output stat_t               status,
	output logic [VALUE_W-1:0]  read_value,
	output logic [OCC_W-1:0]    occupancy
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW:0]   DEPTH_W   = (PW+1)'(DEPTH);
	localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);

	logic [VALUE_W-1:0] mem [DEPTH];

	logic [PW-1:0] front_q;
	logic [CW-1:0] count_q;
	logic          rev_q;

	stat_t         status_q;
	logic [CW-1:0] occ_q;
	logic          rd_ok_q;
	logic [VALUE_W-1:0] rd_data_q;

	logic [PW-1:0] front_d;
	logic [CW-1:0] count_d;
	logic          rev_d;
	stat_t         status_d;
	logic          rd_ok_d;
	logic          wr_en;
	logic [PW-1:0] wr_addr;
	logic [PW-1:0] rd_addr;

	logic          full;
	logic          empty;
	logic [PW-1:0] slot_low;
	logic [PW-1:0] slot_high;
	logic [PW-1:0] front_inc;
	logic [OCC_W-1:0] pos_x;
	logic [OCC_W-1:0] cnt_x;
	logic [OCC_W-1:0] off_x;

	// ring addition, correct while off is below DEPTH
	function automatic logic [PW-1:0] slot_add(input logic [PW-1:0] base,
			input logic [PW-1:0] off);
		logic [PW:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= DEPTH_W) begin
			sum = sum - DEPTH_W;
		end
		return sum[PW-1:0];
	endfunction

	assign full      = (count_q == DEPTH_C);
	assign empty     = (count_q == '0);
	assign slot_low  = (front_q == '0) ? LAST_SLOT : front_q - PW'(1);
	assign slot_high = slot_add(front_q, count_q[PW-1:0]);
	assign front_inc = slot_add(front_q, PW'(1));

	assign pos_x = {1'b0, position};
	assign cnt_x = OCC_W'(count_q);
	assign off_x = rev_q ? (cnt_x - OCC_W'(1) - pos_x) : pos_x;
	assign rd_addr = slot_add(front_q, off_x[PW-1:0]);

	always_comb begin
		front_d  = front_q;
		count_d  = count_q;
		rev_d    = rev_q;
		status_d = STAT_OK;
		rd_ok_d  = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = slot_high;
		unique case (req)
			REQ_APPEND, REQ_INSERT: begin
				if (full) begin
					status_d = STAT_FULL;
				end else begin
					wr_en   = 1'b1;
					count_d = count_q + CW'(1);
					// append goes low when reversed, insert goes low when not
					if (rev_q == (req == REQ_APPEND)) begin
						wr_addr = slot_low;
						front_d = slot_low;
					end
				end
			end
			REQ_POP_FIRST, REQ_POP_LAST: begin
				if (empty) begin
					status_d = STAT_EMPTY;
				end else begin
					count_d = count_q - CW'(1);
					if (rev_q == (req == REQ_POP_LAST)) begin
						front_d = front_inc;
					end
				end
			end
			REQ_READ: begin
				if (pos_x >= cnt_x) begin
					status_d = STAT_RANGE;
				end else begin
					rd_ok_d = 1'b1;
				end
			end
			REQ_REVERSE: rev_d = ~rev_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q  <= '0;
			count_q  <= '0;
			rev_q    <= 1'b0;
			status_q <= STAT_OK;
			occ_q    <= '0;
			rd_ok_q  <= 1'b0;
		end else if (cmd.load) begin
			front_q  <= front_d;
			count_q  <= count_d;
			rev_q    <= rev_d;
			status_q <= status_d;
			occ_q    <= count_d;
			rd_ok_q  <= rd_ok_d;
		end
	end

	// write slot is never an occupied one, so no clash with the read slot
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (wr_en) begin
				mem[wr_addr] <= value;
			end
			rd_data_q <= mem[rd_addr];
		end
	end

	assign status     = status_q;
	assign read_value = rd_ok_q ? rd_data_q : '0;
	assign occupancy  = OCC_W'(occ_q);
	assign dp_stat.full  = full;
	assign dp_stat.empty = empty;

endmodule

### rtl/reversible_deque_store.sv
// result: the result of a transaction is offered in the cycle after it is accepted
// flow: no new request is taken while a result is pending; the controller holds each
//   request until its result has been taken, and every request costs one ring access
// reset: arst_n clears pointers, count and direction flag at once; the ring
//   contents are not cleared and need no clearing pass
module reversible_deque_store
	import rds_pkg::*;
#(
	parameter int unsigned DEPTH = 16
)
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,  // value[31:0], position[43:32], zero pad
	input  logic [REQ_W-1:0]      s_tuser,  // req_type[2:0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,  // read_value[31:0], occupancy[44:32], zero pad
	output logic [STAT_W-1:0]     m_tuser   // status[1:0]
);

	rds_cmd_t           cmd;
	rds_stat_t          dp_stat;
	stat_t              status;
	logic [VALUE_W-1:0] read_value;
	logic [OCC_W-1:0]   occupancy;
	logic               busy_full;

	rds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.out_ready (m_tready),
		.dp_stat   (dp_stat),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.cmd       (cmd),
		.busy_full (busy_full)
	);

	rds_datapath #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.req        (req_t'(s_tuser)),
		.value      (s_tdata[VALUE_W-1:0]),
		.position   (s_tdata[VALUE_W+POS_W-1:VALUE_W]),
		.dp_stat    (dp_stat),
		.status     (status),
		.read_value (read_value),
		.occupancy  (occupancy)
	);

	assign m_tdata = {(M_TDATA_W-VALUE_W-OCC_W)'(busy_full & 1'b0), occupancy, read_value};
	assign m_tuser = status;

endmodule

### rtl/rds_checker.sv
module rds_checker
	import rds_pkg::*;
#(
	parameter int unsigned DEPTH = 16
)
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [M_TDATA_W-1:0]  m_tdata,
	input logic [STAT_W-1:0]     m_tuser
);

	// one request in flight at a time
	a_no_accept_while_resp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input accepted while a result is pending");

	a_resp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> m_tvalid)
		else $error("no result after an accepted transaction");

	a_resp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != STAT_OK) |-> (m_tdata[31:0] == '0))
		else $error("failed request returned a read value");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[44:32] <= OCC_W'(DEPTH)))
		else $error("occupancy beyond depth");

endmodule

bind reversible_deque_store rds_checker #(.DEPTH(DEPTH)) u_rds_checker (.*);

### verif/reversible_deque_store_test.sv
module reversible_deque_store_test;
	timeunit 1ns;
	timeprecision 1ps;
	import rds_pkg::*;

	localparam int unsigned RING_DEPTH    = 16;
	localparam int unsigned RANDOM_ITEMS  = 650;
	localparam int unsigned RUN_LIMIT     = 200000;
	localparam int unsigned LONG_HOLD     = 90;
	localparam int unsigned HOLD_AT_REPLY = 250;
	localparam int unsigned MAX_SHOWN     = 10;

	// request codes the block must ignore
	localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd6;
	localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd7;

	typedef struct packed {
		logic [REQ_W-1:0]   code;
		logic [VALUE_W-1:0] value;
		logic [POS_W-1:0]   pos;
	} request_t;

	typedef struct packed {
		stat_t              status;
		logic [VALUE_W-1:0] read_value;
		logic [OCC_W-1:0]   occupancy;
	} reply_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic [REQ_W-1:0]     s_tuser  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [STAT_W-1:0]    m_tuser;

	request_t    pending_requests[$];
	reply_t      expected_replies[$];
	int unsigned total_requests  = 0;
	int unsigned requests_taken  = 0;
	int unsigned replies_seen    = 0;
	int unsigned fault_count     = 0;
	int unsigned cycle_count     = 0;
	int unsigned send_gap        = 0;
	int unsigned sent_count      = 0;
	int unsigned take_wait       = 0;
	int unsigned replies_taken   = 0;

	// shadow of the ring store
	logic [VALUE_W-1:0] ring [RING_DEPTH];
	int unsigned        head_slot = 0;
	int unsigned        fill      = 0;
	bit                 flipped   = 1'b0;

	reversible_deque_store #(
		.DEPTH(RING_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void add_request(logic [REQ_W-1:0] code, logic [VALUE_W-1:0] value,
		logic [POS_W-1:0] pos);
		request_t rq;
		rq.code  = code;
		rq.value = value;
		rq.pos   = pos;
		pending_requests.push_back(rq);
	endfunction

	// applies one request to the shadow store and returns the reply it should give
	function automatic reply_t serve_request(request_t rq);
		reply_t      r;
		int unsigned off;
		r.status     = STAT_OK;
		r.read_value = '0;
		case (rq.code)
			REQ_APPEND, REQ_INSERT: begin
				if (fill >= RING_DEPTH) begin
					r.status = STAT_FULL;
				end else if ((rq.code == REQ_INSERT) != flipped) begin
					head_slot = (head_slot + RING_DEPTH - 1) % RING_DEPTH;
					ring[head_slot] = rq.value;
					fill++;
				end else begin
					ring[(head_slot + fill) % RING_DEPTH] = rq.value;
					fill++;
				end
			end
			REQ_POP_FIRST, REQ_POP_LAST: begin
				if (fill == 0) begin
					r.status = STAT_EMPTY;
				end else if ((rq.code == REQ_POP_FIRST) != flipped) begin
					head_slot = (head_slot + 1) % RING_DEPTH;
					fill--;
				end else begin
					fill--;
				end
			end
			REQ_READ: begin
				if (rq.pos >= fill) begin
					r.status = STAT_RANGE;
				end else begin
					// reversed order counts from the physical high end
					off = flipped ? (fill - 1 - rq.pos) : rq.pos;
					r.read_value = ring[(head_slot + off) % RING_DEPTH];
				end
			end
			REQ_REVERSE: begin
				flipped = !flipped;
			end
			default: ;
		endcase
		r.occupancy = OCC_W'(fill);
		return r;
	endfunction

	function automatic void flag_mismatch(string what, logic [VALUE_W-1:0] want,
		logic [VALUE_W-1:0] got);
		fault_count++;
		if (fault_count <= MAX_SHOWN)
			$display("mismatch at reply %0d, %s: expected %0h, got %0h",
				replies_seen, what, want, got);
	endfunction

	// request driver
	always @(posedge clk) begin
		request_t rq;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			send_gap = 0;
		end else if (!s_tvalid || s_tready) begin
			if (send_gap > 0) begin
				s_tvalid <= 1'b0;
				send_gap--;
			end else if (pending_requests.size() != 0) begin
				rq = pending_requests.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= rq.code;
				s_tdata  <= S_TDATA_W'({rq.pos, rq.value});
				sent_count++;
				// every fourth stretch of 64 goes back to back
				send_gap = ((sent_count / 64) % 4 == 3) ? 0 : $urandom_range(0, 6);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// reply receiver
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			take_wait = 0;
		end else if (m_tvalid && m_tready) begin
			replies_taken++;
			if (replies_taken == HOLD_AT_REPLY)
				take_wait = LONG_HOLD;
			else if ((replies_taken / 64) % 4 == 1)
				take_wait = 0;
			else
				take_wait = $urandom_range(0, 6);
			if (take_wait == 0) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				take_wait--;
			end
		end else if (take_wait > 0) begin
			m_tready <= 1'b0;
			take_wait--;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// monitor: predicts on each accepted request, checks each accepted reply
	always @(posedge clk) begin
		request_t rq;
		reply_t   got;
		reply_t   want;
		if (!arst_n) begin
			head_slot = 0;
			fill      = 0;
			flipped   = 1'b0;
			expected_replies.delete();
		end else begin
			if (s_tvalid && s_tready) begin
				rq.code  = s_tuser;
				rq.value = s_tdata[VALUE_W-1:0];
				rq.pos   = s_tdata[VALUE_W+POS_W-1:VALUE_W];
				expected_replies.push_back(serve_request(rq));
				requests_taken++;
			end
			if (m_tvalid && m_tready) begin
				replies_seen++;
				got.status     = stat_t'(m_tuser);
				got.read_value = m_tdata[VALUE_W-1:0];
				got.occupancy  = m_tdata[VALUE_W+OCC_W-1:VALUE_W];
				if (expected_replies.size() == 0) begin
					flag_mismatch("reply with nothing outstanding", '0, got.read_value);
				end else begin
					want = expected_replies.pop_front();
					if (got.status !== want.status)
						flag_mismatch("status", VALUE_W'(want.status),
							VALUE_W'(got.status));
					if (got.read_value !== want.read_value)
						flag_mismatch("read_value", want.read_value, got.read_value);
					if (got.occupancy !== want.occupancy)
						flag_mismatch("occupancy", VALUE_W'(want.occupancy),
							VALUE_W'(got.occupancy));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int unsigned       phase;
		int unsigned       roll;
		int unsigned       push_pct;
		int unsigned       pop_pct;
		logic [REQ_W-1:0]  code;
		logic [VALUE_W-1:0] value;
		logic [POS_W-1:0]  pos;

		// empty store, unused codes, both ends, reversal with one and two values
		add_request(REQ_POP_FIRST, 32'h0, 12'd0);
		add_request(REQ_POP_LAST, 32'h0, 12'd0);
		add_request(REQ_READ, 32'h0, 12'hfff);
		add_request(REQ_READ, 32'h0, 12'd0);
		add_request(REQ_REVERSE, 32'h0, 12'd0);
		add_request(REQ_SPARE_A, 32'hffff_ffff, 12'hfff);
		add_request(REQ_SPARE_B, 32'h0, 12'd0);
		add_request(REQ_INSERT, 32'h8000_0000, 12'd0);
		add_request(REQ_REVERSE, 32'h0, 12'd0);
		add_request(REQ_APPEND, 32'h7fff_ffff, 12'd0);
		add_request(REQ_READ, 32'h0, 12'd0);
		add_request(REQ_READ, 32'h0, 12'd1);
		add_request(REQ_READ, 32'h0, 12'd2);
		add_request(REQ_REVERSE, 32'h0, 12'd0);
		add_request(REQ_READ, 32'h0, 12'd0);
		add_request(REQ_INSERT, 32'hffff_ffff, 12'd0);
		add_request(REQ_READ, 32'h0, 12'd2);
		add_request(REQ_POP_LAST, 32'h0, 12'd0);
		add_request(REQ_POP_FIRST, 32'h0, 12'd0);
		add_request(REQ_POP_LAST, 32'h0, 12'd0);
		add_request(REQ_POP_FIRST, 32'h0, 12'd0);

		// stretches of 40 lean towards filling, mixing, draining, mixing
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			phase    = (n / 40) % 4;
			push_pct = (phase == 0) ? 80 : (phase == 2) ? 15 : 45;
			pop_pct  = (phase == 0) ? 8 : (phase == 2) ? 65 : 30;
			roll     = $urandom_range(0, 99);
			if (roll < push_pct)
				code = $urandom_range(0, 1) ? REQ_APPEND : REQ_INSERT;
			else if (roll < push_pct + pop_pct)
				code = $urandom_range(0, 1) ? REQ_POP_FIRST : REQ_POP_LAST;
			else if (roll < 96)
				code = REQ_READ;
			else if (roll < 99)
				code = REQ_REVERSE;
			else
				code = $urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B;
			case ($urandom_range(0, 15))
				0:       value = 32'h8000_0000;
				1:       value = 32'h7fff_ffff;
				2:       value = 32'hffff_ffff;
				3:       value = 32'h0;
				default: value = $urandom;
			endcase
			pos = ($urandom_range(0, 5) == 0) ? POS_W'($urandom_range(0, 4095))
				: POS_W'($urandom_range(0, RING_DEPTH + 1));
			add_request(code, value, pos);
		end
		total_requests = pending_requests.size();

		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (requests_taken < total_requests || expected_replies.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		if (fault_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
